// ===== src/lsm_write_buffer_macros.svh =====
// Assertion macros shared by the write buffer RTL.
`ifndef LSM_WRITE_BUFFER_MACROS_SVH
`define LSM_WRITE_BUFFER_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define LSM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("lsm_write_buffer assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsm_write_buffer assertion failed");

`endif

// ===== src/lsmwb_pkg.sv =====
// Types and codes of the write buffer.
`default_nettype none
package lsmwb_pkg;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_LOOKUP = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ST_HIT     = 2'd0;
   localparam logic [1:0] ST_DELETED = 2'd1;
   localparam logic [1:0] ST_MISS    = 2'd2;
   localparam logic [1:0] ST_FLUSH   = 2'd3;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] item_key;
      logic signed [31:0] item_value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] out_key;
      logic signed [31:0] out_value;
      logic               out_deleted;
      logic               last;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [31:0] key;
      logic signed [31:0] value;
      logic               tomb;
   } entry_type;

endpackage
`default_nettype wire

// ===== src/lsm_if.sv =====
// Valid/ready channel interfaces for requests and responses.
`default_nettype none
interface lsm_req_if;
   logic                       valid;
   logic                       ready;
   lsmwb_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lsm_rsp_if;
   logic                       valid;
   logic                       ready;
   lsmwb_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/lsm_write_buffer.sv =====
// Key-value write buffer with newest-first log, lookup and sorted flush.
//
// Channels: req_ch carries items {kind, item_key, item_value}; rsp_ch
// carries result items {status, out_key, out_value, out_deleted, last}.
// Both use valid/ready; an item moves when both are high at a clock edge.
// The block handles one request item at a time; req_ch.ready is high only
// while idle.
// Write/delete with room: stored, no result.
// Lookup: one entry read per cycle from the newest down until the key
//   matches or the oldest entry is read (no scan for an empty buffer).
// Write/delete on a full buffer: flush by repeated selection. Each pass
//   scans all BUFFER_DEPTH entries (one memory read per cycle) for the
//   smallest key above the last one emitted, newest entry winning ties.
//   With n distinct keys that is (n+1) passes; the single-port read of
//   the entry memory sets the length of each pass. Each flushed item
//   leaves one pass late so that its last flag is known. Afterwards the
//   new entry is stored and the buffer holds only it.
// Reset (synchronous, active high) empties the buffer (fill count zero);
//   the entry memory is not cleared.
// A stalled rsp_ch holds the result register and the scan waits.
`default_nettype none
module lsm_write_buffer #(
   parameter int BUFFER_DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lsm_req_if.sink    req_ch,
   lsm_rsp_if.source  rsp_ch
);
   import lsmwb_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 2) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int FW = $clog2(BUFFER_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   // entry memory, one synchronous read port
   entry_type mem [BUFFER_DEPTH];
   entry_type rdata_ff;
   logic [AW-1:0] rd_addr;
   logic          we;
   logic [AW-1:0] wa;
   entry_type     wd;

   state_type        state_ff, state_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             flush_ff, flush_in;     // current op is a flush
   entry_type        new_ff, new_in;         // request key / pending entry
   logic [AW-1:0]    cur_ff, cur_in;         // index held in rdata_ff
   logic             cand_ok_ff, cand_ok_in;
   entry_type        cand_ff, cand_in;       // best entry of this pass
   logic             prev_ok_ff, prev_ok_in;
   logic signed [31:0] prev_key_ff, prev_key_in;
   logic             pend_ok_ff, pend_ok_in;  // found but not yet emitted
   entry_type        pend_ff, pend_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic      full;
   logic      better;
   logic      found_nx;
   entry_type cand_nx;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[rd_addr];
   end

   assign full = (fill_ff == FW'(BUFFER_DEPTH));

   // flush selection: above the last emitted key, below the candidate
   always_comb begin
      better = (!prev_ok_ff || (rdata_ff.key > prev_key_ff)) &&
               (!cand_ok_ff || (rdata_ff.key < cand_ff.key));
      cand_nx  = better ? rdata_ff : cand_ff;
      found_nx = cand_ok_ff || better;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      flush_in    = flush_ff;
      new_in      = new_ff;
      cur_in      = cur_ff;
      cand_ok_in  = cand_ok_ff;
      cand_in     = cand_ff;
      prev_ok_in  = prev_ok_ff;
      prev_key_in = prev_key_ff;
      pend_ok_in  = pend_ok_ff;
      pend_in     = pend_ff;
      rsp_in      = rsp_ff;
      rd_addr     = cur_ff - 1'b1;
      we          = 1'b0;
      wa          = fill_ff[AW-1:0];
      wd          = new_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               new_in.key   = req_ch.payload.item_key;
               new_in.value = (req_ch.payload.kind == KIND_WRITE) ?
                              req_ch.payload.item_value : 32'sd0;
               new_in.tomb  = (req_ch.payload.kind == KIND_DELETE);
               case (req_ch.payload.kind)
                  KIND_WRITE, KIND_DELETE: begin
                     if (full) begin
                        flush_in   = 1'b1;
                        pend_ok_in = 1'b0;
                        prev_ok_in = 1'b0;
                        cand_ok_in = 1'b0;
                        rd_addr    = AW'(fill_ff - 1'b1);
                        cur_in     = AW'(fill_ff - 1'b1);
                        state_in   = S_SCAN;
                     end else begin
                        we      = 1'b1;
                        wd      = new_in;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  KIND_LOOKUP: begin
                     flush_in = 1'b0;
                     if (fill_ff == '0) begin
                        rsp_in   = '{ST_MISS, req_ch.payload.item_key, 32'sd0, 1'b0, 1'b1};
                        state_in = S_OUT;
                     end else begin
                        rd_addr  = AW'(fill_ff - 1'b1);
                        cur_in   = AW'(fill_ff - 1'b1);
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (!flush_ff) begin
               if (rdata_ff.key == new_ff.key) begin
                  if (rdata_ff.tomb) begin
                     rsp_in = '{ST_DELETED, new_ff.key, 32'sd0, 1'b0, 1'b1};
                  end else begin
                     rsp_in = '{ST_HIT, new_ff.key, rdata_ff.value, 1'b0, 1'b1};
                  end
                  state_in = S_OUT;
               end else if (cur_ff == '0) begin
                  rsp_in   = '{ST_MISS, new_ff.key, 32'sd0, 1'b0, 1'b1};
                  state_in = S_OUT;
               end else begin
                  cur_in = cur_ff - 1'b1;
               end
            end else if (cur_ff != '0) begin
               cand_in    = cand_nx;
               cand_ok_in = found_nx;
               cur_in     = cur_ff - 1'b1;
            end else begin
               // end of pass
               prev_ok_in  = 1'b1;
               prev_key_in = cand_nx.key;
               pend_in     = cand_nx;
               pend_ok_in  = found_nx;
               cand_ok_in  = 1'b0;
               if (pend_ok_ff) begin
                  rsp_in = '{ST_FLUSH, pend_ff.key,
                             pend_ff.tomb ? 32'sd0 : pend_ff.value,
                             pend_ff.tomb, !found_nx};
                  state_in = S_OUT;
               end else begin
                  rd_addr = AW'(fill_ff - 1'b1);
                  cur_in  = AW'(fill_ff - 1'b1);
               end
            end
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               if (flush_ff && pend_ok_ff) begin
                  rd_addr  = AW'(fill_ff - 1'b1);
                  cur_in   = AW'(fill_ff - 1'b1);
                  state_in = S_SCAN;
               end else if (flush_ff) begin
                  // flush done: buffer holds only the new entry
                  we       = 1'b1;
                  wa       = '0;
                  fill_in  = FW'(1);
                  flush_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         fill_ff    <= '0;
         flush_ff   <= 1'b0;
         cand_ok_ff <= 1'b0;
         prev_ok_ff <= 1'b0;
         pend_ok_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         flush_ff   <= flush_in;
         cand_ok_ff <= cand_ok_in;
         prev_ok_ff <= prev_ok_in;
         pend_ok_ff <= pend_ok_in;
      end
      new_ff      <= new_in;
      cur_ff      <= cur_in;
      cand_ff     <= cand_in;
      prev_key_ff <= prev_key_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = (state_ff == S_OUT);
   assign rsp_ch.payload = rsp_ff;

`include "lsm_write_buffer_macros.svh"

   `LSM_ASSERT(a_fill_range, fill_ff <= FW'(BUFFER_DEPTH))
   `LSM_ASSERT(a_lookup_last, !(rsp_ch.valid && rsp_ff.status != ST_FLUSH) || rsp_ff.last)
   `LSM_ASSERT_NEXT(a_store_grows,
      req_ch.valid && req_ch.ready && !full &&
      (req_ch.payload.kind == KIND_WRITE || req_ch.payload.kind == KIND_DELETE),
      fill_ff == $past(fill_ff) + 1'b1)
   `LSM_ASSERT_NEXT(a_flush_ends_one,
      rsp_ch.valid && rsp_ch.ready && flush_ff && !pend_ok_ff,
      fill_ff == FW'(1) && state_ff == S_IDLE)

endmodule
`default_nettype wire
